// File: rtl/pbe_pkg.sv
// Shared constants, types and helpers of the PackBits encoder.
package pbe_pkg;

	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned LANES           = 8;
	localparam int unsigned WORD_W          = BYTE_W * LANES;
	localparam int unsigned OCNT_W          = 4;
	localparam int unsigned LANE_W          = $clog2(LANES);
	localparam int unsigned LITERAL_MAX_DEF = 128;
	localparam int unsigned RUN_MAX_DEF     = 127;
	localparam int unsigned MIN_REPEAT      = 3;
	// literal ring: 256 entries covers the 130 held bytes plus blocks still being read
	localparam int unsigned ADDR_W          = 8;
	localparam int unsigned PTR_W           = ADDR_W + 1;
	localparam int unsigned QUEUE_DEPTH     = 4;

	// One coded segment: a run (header, value) or a literal block (header, start in the ring)
	typedef struct packed {
		logic              vld;
		logic              is_run;
		logic [BYTE_W-1:0] hdr;
		logic [BYTE_W-1:0] val;
		logic [PTR_W-1:0]  start;
	} seg_t;

	// Everything one input byte emits, at most two segments
	typedef struct packed {
		seg_t seg_a;
		seg_t seg_b;
		logic last;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_t;

	// Back end status seen by the front end
	typedef struct packed {
		logic             busy;
		logic             rel_vld;
		logic [PTR_W-1:0] rel_ptr;
	} bk_stat_t;

	function automatic seg_t mk_run(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] val);
		seg_t s;
		s.vld    = 1'b1;
		s.is_run = 1'b1;
		s.hdr    = BYTE_W'(9'd257 - {1'b0, len});
		s.val    = val;
		s.start  = '0;
		return s;
	endfunction

	function automatic seg_t mk_lit(input logic [PTR_W-1:0] start, input logic [BYTE_W-1:0] n);
		seg_t s;
		s.vld    = 1'b1;
		s.is_run = 1'b0;
		s.hdr    = n - BYTE_W'(1);
		s.val    = '0;
		s.start  = start;
		return s;
	endfunction

endpackage

// File: rtl/pbe_stream_if.sv
// Handshake interfaces for source bytes and coded result words.
interface pbe_item_if;
	logic                      valid;
	logic                      ready;
	logic [pbe_pkg::BYTE_W-1:0] in_byte;
	logic                      in_last;

	modport source(output valid, in_byte, in_last, input ready);
	modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface pbe_result_if;
	logic                       valid;
	logic                       ready;
	logic [pbe_pkg::WORD_W-1:0] out_word;
	logic [pbe_pkg::OCNT_W-1:0] out_count;
	logic                       out_last;
	logic                       out_stream_end;

	modport source(output valid, out_word, out_count, out_last, out_stream_end, input ready);
	modport sink(input valid, out_word, out_count, out_last, out_stream_end, output ready);
endinterface

// File: rtl/pbe_front.sv
// Front end: run/literal tracking, literal ring writes, segment commands.
module pbe_front #(
	parameter int unsigned LITERAL_MAX = pbe_pkg::LITERAL_MAX_DEF,
	parameter int unsigned RUN_MAX     = pbe_pkg::RUN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pbe_item_if.sink          item,
	input  logic              q_full,
	input  logic              q_empty,
	output logic              push,
	output pbe_pkg::entry_t   push_data,
	output pbe_pkg::wr_t      wr,
	input  pbe_pkg::bk_stat_t bk
);
	import pbe_pkg::*;

	localparam int unsigned LCW = $clog2(LITERAL_MAX + 3);
	localparam int unsigned RLW = $clog2(RUN_MAX + 1);

	logic [PTR_W-1:0]  head_q, tail_q;
	logic [LCW-1:0]    cnt_q;
	logic              in_run_q;
	logic [BYTE_W-1:0] run_val_q, prev1_q, prev2_q;
	logic [RLW-1:0]    run_len_q;

	logic [PTR_W-1:0]  n_head, wr_ptr, tail_eff, used;
	logic [LCW-1:0]    n_cnt;
	logic              n_run, push_lit, idle, accept;
	logic [BYTE_W-1:0] n_val, n_p1, n_p2, b;
	logic [RLW-1:0]    n_len;
	seg_t              s0, s1, sn;

	assign b        = item.in_byte;
	assign wr_ptr   = head_q + PTR_W'(cnt_q);
	assign idle     = q_empty && !bk.busy;
	assign tail_eff = idle ? head_q : tail_q;
	assign used     = wr_ptr - tail_eff;
	assign item.ready = !q_full && !used[PTR_W-1];
	assign accept   = item.valid && item.ready;

	always_comb begin
		n_head   = head_q;
		n_cnt    = cnt_q;
		n_run    = in_run_q;
		n_val    = run_val_q;
		n_len    = run_len_q;
		n_p1     = prev1_q;
		n_p2     = prev2_q;
		push_lit = 1'b0;
		s0       = '0;
		s1       = '0;
		sn       = '0;

		if (in_run_q) begin
			if (b == run_val_q) begin
				n_len = run_len_q + RLW'(1);
				if (n_len >= RLW'(RUN_MAX)) begin
					s0    = mk_run(BYTE_W'(n_len), run_val_q);
					n_run = 1'b0;
					n_len = '0;
				end
			end else begin
				s0       = mk_run(BYTE_W'(run_len_q), run_val_q);
				n_run    = 1'b0;
				n_len    = '0;
				push_lit = 1'b1;
			end
		end else begin
			push_lit = 1'b1;
		end

		if (push_lit) begin
			if (cnt_q >= LCW'(2) && prev1_q == b && prev2_q == b) begin
				// third equal byte: held literals before the triple go out first
				if (cnt_q > LCW'(2)) begin
					sn = mk_lit(head_q, BYTE_W'(cnt_q - LCW'(2)));
					if (!s0.vld) s0 = sn; else s1 = sn;
				end
				n_head = wr_ptr + PTR_W'(1);
				n_cnt  = '0;
				n_run  = 1'b1;
				n_val  = b;
				n_len  = RLW'(MIN_REPEAT);
				if (RUN_MAX <= MIN_REPEAT) begin
					sn    = mk_run(BYTE_W'(MIN_REPEAT), b);
					if (!s0.vld) s0 = sn; else s1 = sn;
					n_run = 1'b0;
					n_len = '0;
				end
			end else if (cnt_q == LCW'(LITERAL_MAX + 1)) begin
				sn     = mk_lit(head_q, BYTE_W'(LITERAL_MAX));
				if (!s0.vld) s0 = sn; else s1 = sn;
				n_head = head_q + PTR_W'(LITERAL_MAX);
				n_cnt  = LCW'(2);
			end else begin
				n_cnt = cnt_q + LCW'(1);
			end
			n_p2 = prev1_q;
			n_p1 = b;
		end

		if (item.in_last) begin
			if (n_run) begin
				sn = mk_run(BYTE_W'(n_len), n_val);
				if (!s0.vld) s0 = sn; else s1 = sn;
			end
			n_run = 1'b0;
			n_len = '0;
			if (n_cnt != '0) begin
				if (n_cnt <= LCW'(LITERAL_MAX)) begin
					sn = mk_lit(n_head, BYTE_W'(n_cnt));
					if (!s0.vld) s0 = sn; else s1 = sn;
				end else begin
					sn = mk_lit(n_head, BYTE_W'(LITERAL_MAX));
					if (!s0.vld) s0 = sn; else s1 = sn;
					sn = mk_lit(n_head + PTR_W'(LITERAL_MAX), BYTE_W'(n_cnt - LCW'(LITERAL_MAX)));
					if (!s0.vld) s0 = sn; else s1 = sn;
				end
			end
			n_head = n_head + PTR_W'(n_cnt);
			n_cnt  = '0;
		end
	end

	assign push            = accept && s0.vld;
	assign push_data.seg_a = s0;
	assign push_data.seg_b = s1;
	assign push_data.last  = item.in_last;

	assign wr.en   = accept && push_lit;
	assign wr.addr = wr_ptr[ADDR_W-1:0];
	assign wr.data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			in_run_q  <= 1'b0;
			run_val_q <= '0;
			run_len_q <= '0;
			prev1_q   <= '0;
			prev2_q   <= '0;
		end else begin
			if (idle) begin
				tail_q <= head_q;
			end else if (bk.rel_vld) begin
				tail_q <= bk.rel_ptr;
			end
			if (accept) begin
				head_q    <= n_head;
				cnt_q     <= n_cnt;
				in_run_q  <= n_run;
				run_val_q <= n_val;
				run_len_q <= n_len;
				prev1_q   <= n_p1;
				prev2_q   <= n_p2;
			end
		end
	end

endmodule

// File: rtl/pbe_queue.sv
// Small command queue between the front and back ends.
module pbe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pbe_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output pbe_pkg::entry_t pop_data,
	output logic            empty
);
	import pbe_pkg::*;

	localparam int unsigned QPW = $clog2(QUEUE_DEPTH);

	entry_t         slot_q [QUEUE_DEPTH];
	logic [QPW-1:0] wp_q, rp_q;
	logic [QPW:0]   fill_q;

	assign full     = fill_q == (QPW+1)'(QUEUE_DEPTH);
	assign empty    = fill_q == '0;
	assign pop_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPW+1)'(1);
			end
		end
	end

endmodule

// File: rtl/pbe_back.sv
// Back end: literal ring, byte sequencer and eight-lane result packer.
module pbe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pbe_pkg::wr_t       wr,
	input  logic               q_empty,
	input  pbe_pkg::entry_t    q_data,
	output logic               pop,
	output pbe_pkg::bk_stat_t  stat,
	pbe_result_if.source       result
);
	import pbe_pkg::*;

	localparam int unsigned DEPTH = 1 << ADDR_W;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	// sequencer
	entry_t            ent_q;
	logic              busy_q, seg_sel_q;
	logic [BYTE_W-1:0] idx_q;
	seg_t              cur;
	logic [BYTE_W-1:0] last_idx, imm;
	logic              seg_done, step_done, from_mem, adv, load;
	logic [ADDR_W-1:0] rd_addr;

	// byte stage
	logic              vld_s2, mem_s2, eos_s2, end_s2;
	logic [BYTE_W-1:0] imm_s2, byte_s2;
	logic              take_s2, consume_s2, emits_s2, out_free;

	// packer and output register
	logic [WORD_W-1:0] acc_q, word_n;
	logic [LANE_W-1:0] lane_q;
	logic              out_vld_q;

	assign cur       = seg_sel_q ? ent_q.seg_b : ent_q.seg_a;
	assign last_idx  = cur.is_run ? BYTE_W'(1) : cur.hdr + BYTE_W'(1);
	assign seg_done  = idx_q == last_idx;
	assign step_done = seg_done && (seg_sel_q || !ent_q.seg_b.vld);
	assign from_mem  = !cur.is_run && idx_q != '0;
	assign imm       = (idx_q == '0) ? cur.hdr : cur.val;
	assign rd_addr   = ADDR_W'(cur.start + PTR_W'(idx_q) - PTR_W'(1));

	assign out_free   = !out_vld_q || result.ready;
	assign emits_s2   = lane_q == LANE_W'(LANES - 1) || eos_s2;
	assign consume_s2 = vld_s2 && (!emits_s2 || out_free);
	assign take_s2    = !vld_s2 || consume_s2;
	assign adv        = busy_q && take_s2;
	assign load       = (!busy_q || (adv && step_done)) && !q_empty;
	assign pop        = load;
	assign byte_s2    = mem_s2 ? rdata_q : imm_s2;

	assign stat.busy    = busy_q;
	assign stat.rel_vld = adv && seg_done && !cur.is_run;
	assign stat.rel_ptr = cur.start + PTR_W'(last_idx);

	always_comb begin
		word_n = acc_q;
		for (int i = 0; i < LANES; i++) begin
			if (lane_q == LANE_W'(i)) begin
				word_n[i*BYTE_W +: BYTE_W] = byte_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (adv && from_mem) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= q_data;
		end
		if (adv) begin
			imm_s2 <= imm;
			mem_s2 <= from_mem;
			eos_s2 <= step_done;
			end_s2 <= step_done && ent_q.last;
		end
		if (consume_s2 && emits_s2) begin
			result.out_word       <= word_n;
			result.out_count      <= OCNT_W'(lane_q) + OCNT_W'(1);
			result.out_last       <= eos_s2;
			result.out_stream_end <= end_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			seg_sel_q <= 1'b0;
			idx_q     <= '0;
			vld_s2    <= 1'b0;
			acc_q     <= '0;
			lane_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q    <= 1'b1;
				seg_sel_q <= 1'b0;
				idx_q     <= '0;
			end else if (adv) begin
				if (step_done) begin
					busy_q <= 1'b0;
				end else if (seg_done) begin
					seg_sel_q <= 1'b1;
					idx_q     <= '0;
				end else begin
					idx_q <= idx_q + BYTE_W'(1);
				end
			end

			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (consume_s2) begin
				vld_s2 <= 1'b0;
			end

			if (consume_s2) begin
				if (emits_s2) begin
					acc_q  <= '0;
					lane_q <= '0;
				end else begin
					acc_q  <= word_n;
					lane_q <= lane_q + LANE_W'(1);
				end
			end

			if (consume_s2 && emits_s2) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign result.valid = out_vld_q;

endmodule

// File: rtl/packbits_rle_encoder.sv
// PackBits encoder top level: front end, command queue and back end.
//
//   channel  dir  transaction payload
//   item     in   in_byte[7:0], in_last
//   result   out  out_word[63:0], out_count[3:0], out_last, out_stream_end
//
// The front end takes one source byte per cycle while the command queue has room and the
// 256-entry literal ring has a free slot; it emits at most one queue entry per byte.
// The back end sends one coded byte per cycle unless the result port stalls (ring read
// registered). A word packs up to eight bytes; a literal block of n sends n+1, a run 2.
// Reset is asynchronous and clears all control state; the ring needs no clearing pass.
// A stalled result port stalls the back end only; the front runs on until the queue or the
// literal ring fills.
module packbits_rle_encoder #(
	parameter int unsigned LITERAL_MAX = pbe_pkg::LITERAL_MAX_DEF,
	parameter int unsigned RUN_MAX     = pbe_pkg::RUN_MAX_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pbe_item_if.sink     item,
	pbe_result_if.source result
);
	import pbe_pkg::*;

	entry_t   push_data, pop_data;
	wr_t      wr;
	bk_stat_t bk;
	logic     push, pop, q_full, q_empty;

	pbe_front #(
		.LITERAL_MAX(LITERAL_MAX),
		.RUN_MAX    (RUN_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.q_full   (q_full),
		.q_empty  (q_empty),
		.push     (push),
		.push_data(push_data),
		.wr       (wr),
		.bk       (bk)
	);

	pbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	pbe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.q_empty(q_empty),
		.q_data (pop_data),
		.pop    (pop),
		.stat   (bk),
		.result (result)
	);

endmodule

// File: test/tb_packbits_rle_encoder.sv
// Self-checking testbench for the streaming PackBits encoder.
`timescale 1ns / 100ps

module tb_packbits_rle_encoder;

	import pbe_pkg::*;

	localparam int unsigned LITERAL_MAX  = LITERAL_MAX_DEF;
	localparam int unsigned RUN_MAX      = RUN_MAX_DEF;
	localparam int unsigned STORE_DEPTH  = LITERAL_MAX + 2;
	localparam int unsigned DIR_ROWS     = 22;
	localparam int unsigned PHASE_ITEMS  = 60;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned CYCLE_LIMIT  = 500000;

	typedef enum {SHAPE_MIXED, SHAPE_LITERALS, SHAPE_RUN} stream_shape_t;

	// source byte; typed rows carry their single expected word
	typedef struct {
		logic [BYTE_W-1:0] b;
		logic              last;
		bit                typed;
		logic [WORD_W-1:0] word;
		logic [OCNT_W-1:0] cnt;
	} src_item_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [OCNT_W-1:0] cnt;
		logic              lst;
		logic              send;
	} coded_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic res_ready = 1'b0;

	pbe_item_if   item_if();
	pbe_result_if result_if();

	assign result_if.ready = res_ready;

	packbits_rle_encoder #(
		.LITERAL_MAX(LITERAL_MAX),
		.RUN_MAX    (RUN_MAX)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_if),
		.result(result_if)
	);

	always #5 clk = ~clk;

	// encoder image
	logic [BYTE_W-1:0] lit_store [STORE_DEPTH];
	int unsigned       lit_cnt;
	bit                in_run;
	logic [BYTE_W-1:0] run_val;
	int unsigned       run_len;
	logic [BYTE_W-1:0] coded_bytes[$];
	coded_word_t       step_words[$];
	coded_word_t       expected_words[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned streams_sent;
	int unsigned words_checked;
	src_item_t   stream_bytes[$];

	src_item_t dir_rows [DIR_ROWS] = '{
		'{8'h00, 1'b1, 1'b1, 64'h0000, 4'd2},	// lone zero byte
		'{8'hFF, 1'b1, 1'b1, 64'hFF00, 4'd2},	// lone all-ones byte
		'{8'h80, 1'b0, 1'b0, '0, '0},
		'{8'h80, 1'b0, 1'b0, '0, '0},
		'{8'h80, 1'b1, 1'b1, 64'h80FE, 4'd2},	// shortest run, top bit set
		'{8'h01, 1'b0, 1'b0, '0, '0},
		'{8'h02, 1'b0, 1'b0, '0, '0},
		'{8'h02, 1'b0, 1'b0, '0, '0},
		'{8'h02, 1'b0, 1'b0, '0, '0},		// literal flushed ahead of run
		'{8'h03, 1'b0, 1'b0, '0, '0},		// breaks the run
		'{8'h03, 1'b0, 1'b0, '0, '0},
		'{8'h7F, 1'b1, 1'b0, '0, '0},
		'{8'hAA, 1'b0, 1'b0, '0, '0},
		'{8'h55, 1'b0, 1'b0, '0, '0},
		'{8'hAA, 1'b0, 1'b0, '0, '0},
		'{8'h55, 1'b0, 1'b0, '0, '0},
		'{8'hFF, 1'b0, 1'b0, '0, '0},
		'{8'hFF, 1'b0, 1'b0, '0, '0},
		'{8'hFF, 1'b1, 1'b0, '0, '0},		// literals, run and end in one step
		'{8'h5A, 1'b0, 1'b0, '0, '0},
		'{8'h5A, 1'b1, 1'b0, '0, '0},		// pair stays literal
		'{8'h81, 1'b1, 1'b1, 64'h8100, 4'd2}
	};

	function automatic void add_coded_byte(input logic [BYTE_W-1:0] v);
		coded_bytes.insert(coded_bytes.size(), v);
	endfunction

	function automatic void add_step_word(input coded_word_t cw);
		step_words.insert(step_words.size(), cw);
	endfunction

	function automatic void add_expected(input coded_word_t cw);
		expected_words.insert(expected_words.size(), cw);
	endfunction

	function automatic void add_stream_item(input src_item_t it);
		stream_bytes.insert(stream_bytes.size(), it);
	endfunction

	function automatic void put_literal_block(input int unsigned start, input int unsigned n);
		if (n == 0)
			return;
		add_coded_byte(BYTE_W'(n - 1));
		for (int unsigned i = 0; i < n; i++)
			add_coded_byte(lit_store[start + i]);
	endfunction

	function automatic void close_run();
		add_coded_byte(BYTE_W'(257 - run_len));
		add_coded_byte(run_val);
		in_run = 1'b0;
		run_len = 0;
	endfunction

	function automatic void hold_literal(input logic [BYTE_W-1:0] b);
		lit_store[lit_cnt] = b;
		lit_cnt++;
		if (lit_cnt >= MIN_REPEAT && lit_store[lit_cnt - 2] == b &&
				lit_store[lit_cnt - 3] == b) begin
			put_literal_block(0, lit_cnt - MIN_REPEAT);
			lit_cnt = 0;
			in_run = 1'b1;
			run_val = b;
			run_len = MIN_REPEAT;
			if (run_len >= RUN_MAX)
				close_run();
		end else if (lit_cnt >= STORE_DEPTH) begin
			// full block out, the two newest bytes stay held
			put_literal_block(0, LITERAL_MAX);
			lit_store[0] = lit_store[LITERAL_MAX];
			lit_store[1] = lit_store[LITERAL_MAX + 1];
			lit_cnt = 2;
		end
	endfunction

	function automatic void clear_encoder();
		foreach (lit_store[i])
			lit_store[i] = '0;
		lit_cnt = 0;
		in_run = 1'b0;
		run_val = '0;
		run_len = 0;
	endfunction

	// one source byte in, the coded words it releases into step_words
	function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic last);
		bit          taken;
		int unsigned nwords;
		int unsigned n;
		coded_word_t cw;
		taken = 1'b0;
		coded_bytes.delete();
		step_words.delete();
		if (in_run) begin
			if (b == run_val) begin
				run_len++;
				if (run_len >= RUN_MAX)
					close_run();
				taken = 1'b1;
			end else begin
				close_run();
			end
		end
		if (!taken)
			hold_literal(b);
		if (last) begin
			if (in_run)
				close_run();
			if (lit_cnt <= LITERAL_MAX) begin
				put_literal_block(0, lit_cnt);
			end else begin
				put_literal_block(0, LITERAL_MAX);
				put_literal_block(LITERAL_MAX, lit_cnt - LITERAL_MAX);
			end
			lit_cnt = 0;
		end
		nwords = (coded_bytes.size() + LANES - 1) / LANES;
		for (int unsigned w = 0; w < nwords; w++) begin
			n = coded_bytes.size() - w * LANES;
			if (n > LANES)
				n = LANES;
			cw.word = '0;
			for (int unsigned i = 0; i < n; i++)
				cw.word[BYTE_W*i +: BYTE_W] = coded_bytes[w * LANES + i];
			cw.cnt = OCNT_W'(n);
			cw.lst = (w + 1 == nwords);
			cw.send = last && (w + 1 == nwords);
			add_step_word(cw);
		end
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(3))
			0: return BYTE_W'($urandom_range(3));		// small alphabet, chance repeats
			1: return BYTE_W'($urandom_range(8'h81, 8'h7E));	// around the sign boundary
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	function automatic src_item_t plain_item(input logic [BYTE_W-1:0] b);
		src_item_t it;
		it = '{default: '0};
		it.b = b;
		return it;
	endfunction

	function automatic void build_stream(input stream_shape_t shape, input int unsigned len);
		logic [BYTE_W-1:0] v;
		int unsigned       sz;
		stream_bytes.delete();
		case (shape)
			SHAPE_LITERALS: begin
				for (int unsigned i = 0; i < len; i++) begin
					v = BYTE_W'($urandom);
					sz = stream_bytes.size();
					// pairs allowed, never three in a row
					if (sz >= 2 && stream_bytes[sz-1].b == v && stream_bytes[sz-2].b == v)
						v = v + 1'b1;
					add_stream_item(plain_item(v));
				end
			end
			SHAPE_RUN: begin
				repeat ($urandom_range(3))
					add_stream_item(plain_item(pick_byte()));
				v = pick_byte();
				repeat (len)
					add_stream_item(plain_item(v));
				add_stream_item(plain_item(BYTE_W'(v + 1 + $urandom_range(253))));
			end
			default: begin
				repeat ($urandom_range(1, 4)) begin
					v = pick_byte();
					if ($urandom_range(1)) begin
						repeat ($urandom_range(1, 6))
							add_stream_item(plain_item(v));
					end else begin
						repeat ($urandom_range(1, 6))
							add_stream_item(plain_item(pick_byte()));
					end
				end
			end
		endcase
		stream_bytes[stream_bytes.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("ERROR cycle %0d: %s", cycle_count, what);
	endtask

	task automatic drive_byte(input src_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.in_byte <= it.b;
		item_if.in_last <= it.last;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		encode_byte(it.b, it.last);
		if (it.typed)
			add_expected('{it.word, it.cnt, 1'b1, 1'b1});
		else
			foreach (step_words[k])
				add_expected(step_words[k]);
		items_sent++;
		if (it.last)
			streams_sent++;
	endtask

	task automatic wait_all_results();
		item_if.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, expected_words.size());
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin : rx
		coded_word_t want;
		if (arst_n) begin
			if (result_if.valid && res_ready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %h arrived with nothing expected",
						result_if.out_word));
				end else begin
					want = expected_words.pop_front();
					if (result_if.out_word !== want.word)
						report_mismatch($sformatf("out_word %h, want %h",
							result_if.out_word, want.word));
					if (result_if.out_count !== want.cnt)
						report_mismatch($sformatf("out_count %0d, want %0d",
							result_if.out_count, want.cnt));
					if (result_if.out_last !== want.lst)
						report_mismatch($sformatf("out_last %b, want %b",
							result_if.out_last, want.lst));
					if (result_if.out_stream_end !== want.send)
						report_mismatch($sformatf("out_stream_end %b, want %b",
							result_if.out_stream_end, want.send));
				end
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int unsigned phase_start;
		item_if.valid <= 1'b0;
		item_if.in_byte <= '0;
		item_if.in_last <= 1'b0;
		clear_encoder();
		send_idle_pct = 20;
		recv_idle_pct = 50;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			drive_byte(dir_rows[r]);
		// hold the source off until the encoder has drained
		wait_all_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 50;
					// ends with 129 held: two literal blocks at end of stream
					build_stream(SHAPE_LITERALS, LITERAL_MAX + 1);
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 20;
					build_stream(SHAPE_RUN, $urandom_range(RUN_MAX, RUN_MAX + 12));
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					build_stream(SHAPE_LITERALS, $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 10));
				end
			endcase
			phase_start = items_sent;
			foreach (stream_bytes[i])
				drive_byte(stream_bytes[i]);
			while (items_sent - phase_start < PHASE_ITEMS) begin
				build_stream(SHAPE_MIXED, 0);
				foreach (stream_bytes[i])
					drive_byte(stream_bytes[i]);
			end
			wait_all_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d source bytes in %0d streams, %0d coded words compared",
			items_sent, streams_sent, words_checked);
		$display("including capped runs, literal overflow, split end blocks, three stall mixes");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
